// ----- rtl/rgb_led_effect_sequencer_top_assert.svh -----
// Assertion macros used by the checker file.
`ifndef RGB_LED_EFFECT_SEQUENCER_TOP_ASSERT_SVH
`define RGB_LED_EFFECT_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication
`define RLES_ASSERT_NOW(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RLES_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rles_pkg.sv -----
// Types, constants and lookup functions of the LED effect sequencer.
`timescale 1ns / 1ps
package rles_pkg;

  localparam int ADDR_W = 5;
  localparam int PATROL_PHASES = 13;

  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_STEADY  = 3'd1;
  localparam logic [2:0] MODE_BLINK   = 3'd2;
  localparam logic [2:0] MODE_LIMITED = 3'd3;
  localparam logic [2:0] MODE_ALARM   = 3'd4;
  localparam logic [2:0] MODE_PATROL  = 3'd5;

  localparam logic [2:0] HUE_BLACK  = 3'd0;
  localparam logic [2:0] HUE_RED    = 3'd1;
  localparam logic [2:0] HUE_GREEN  = 3'd2;
  localparam logic [2:0] HUE_BLUE   = 3'd3;
  localparam logic [2:0] HUE_YELLOW = 3'd4;
  localparam logic [2:0] HUE_WHITE  = 3'd5;

  localparam logic [2:0] REG_EFFECT_MODE  = 3'd0;
  localparam logic [2:0] REG_COLOR_SELECT = 3'd1;
  localparam logic [2:0] REG_BLINK_TOTAL  = 3'd2;
  localparam logic [2:0] REG_ON_TIME      = 3'd3;
  localparam logic [2:0] REG_OFF_TIME     = 3'd4;

  localparam logic [2:0]  RST_EFFECT_MODE  = MODE_PATROL;
  localparam logic [2:0]  RST_COLOR_SELECT = HUE_WHITE;
  localparam logic [15:0] RST_BLINK_TOTAL  = 16'd1;
  localparam logic [15:0] RST_ON_TIME      = 16'd500;
  localparam logic [15:0] RST_OFF_TIME     = 16'd0;
  localparam logic [15:0] RST_MS_LEFT      = 16'd100;

  localparam logic [15:0] ALARM_LEN = 16'd150;
  localparam logic [7:0]  FULL      = 8'd255;

  localparam logic [15:0] PATROL_LEN [PATROL_PHASES] = '{
    16'd100, 16'd50, 16'd100, 16'd50, 16'd100, 16'd200, 16'd150,
    16'd100, 16'd150, 16'd100, 16'd150, 16'd250, 16'd500
  };

  localparam logic [2:0] PATROL_COL [PATROL_PHASES] = '{
    HUE_RED, HUE_BLACK, HUE_BLUE, HUE_BLACK, HUE_WHITE, HUE_BLACK,
    HUE_RED, HUE_BLACK, HUE_BLUE, HUE_BLACK, HUE_WHITE, HUE_BLACK,
    HUE_BLACK
  };

  typedef struct packed {
    logic [2:0]  effect_mode;
    logic [2:0]  color_select;
    logic [15:0] blink_total;
    logic [15:0] on_time_ms;
    logic [15:0] off_time_ms;
  } cfg_t;

  function automatic logic [3:0] patrol_idx(input logic [3:0] idx);
    return (idx < 4'(PATROL_PHASES)) ? idx : 4'd0;
  endfunction

  function automatic logic [15:0] phase_len(input cfg_t c, input logic [3:0] idx);
    logic [15:0] v;
    v = (idx == 4'd0) ? c.on_time_ms : c.off_time_ms;
    case (c.effect_mode)
      MODE_BLINK, MODE_LIMITED: return (v == 16'd0) ? 16'd1 : v;
      MODE_ALARM:               return ALARM_LEN;
      MODE_PATROL:              return PATROL_LEN[patrol_idx(idx)];
      default:                  return 16'd1;
    endcase
  endfunction

  function automatic logic [2:0] phase_color(input cfg_t c, input logic [3:0] idx);
    case (c.effect_mode)
      MODE_STEADY:              return c.color_select;
      MODE_BLINK, MODE_LIMITED: return (idx == 4'd0) ? c.color_select : HUE_BLACK;
      MODE_ALARM:               return (idx == 4'd0) ? HUE_RED : HUE_BLUE;
      MODE_PATROL:              return PATROL_COL[patrol_idx(idx)];
      default:                  return HUE_BLACK;
    endcase
  endfunction

  function automatic logic [4:0] phase_count(input logic [2:0] mode);
    return (mode == MODE_PATROL) ? 5'(PATROL_PHASES) : 5'd2;
  endfunction

  function automatic logic [23:0] palette(input logic [2:0] col);
    case (col)
      HUE_RED:    return {FULL, 8'd0, 8'd0};
      HUE_GREEN:  return {8'd0, FULL, 8'd0};
      HUE_BLUE:   return {8'd0, 8'd0, FULL};
      HUE_YELLOW: return {FULL, FULL, 8'd0};
      HUE_WHITE:  return {FULL, FULL, FULL};
      default:    return 24'd0;
    endcase
  endfunction

endpackage

// ----- rtl/rles_cfg.sv -----
// APB register file of the LED effect sequencer with restart pulse.
`timescale 1ns / 1ps
module rles_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rles_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output rles_pkg::cfg_t            cfg,
  output logic                      restart
);
  import rles_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.effect_mode  <= RST_EFFECT_MODE;
      cfg.color_select <= RST_COLOR_SELECT;
      cfg.blink_total  <= RST_BLINK_TOTAL;
      cfg.on_time_ms   <= RST_ON_TIME;
      cfg.off_time_ms  <= RST_OFF_TIME;
      restart          <= 1'b0;
    end else begin
      restart <= 1'b0;
      if (wr) begin
        case (idx)
          REG_EFFECT_MODE: begin
            cfg.effect_mode <= pwdata[2:0];
            restart         <= 1'b1;
          end
          REG_COLOR_SELECT: begin
            cfg.color_select <= pwdata[2:0];
            restart          <= 1'b1;
          end
          REG_BLINK_TOTAL: begin
            cfg.blink_total <= pwdata[15:0];
            restart         <= 1'b1;
          end
          REG_ON_TIME: begin
            cfg.on_time_ms <= pwdata[15:0];
            restart        <= 1'b1;
          end
          REG_OFF_TIME: begin
            cfg.off_time_ms <= pwdata[15:0];
            restart         <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      REG_EFFECT_MODE:  prdata = {29'd0, cfg.effect_mode};
      REG_COLOR_SELECT: prdata = {29'd0, cfg.color_select};
      REG_BLINK_TOTAL:  prdata = {16'd0, cfg.blink_total};
      REG_ON_TIME:      prdata = {16'd0, cfg.on_time_ms};
      REG_OFF_TIME:     prdata = {16'd0, cfg.off_time_ms};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/rles_core.sv -----
// Phase state of the LED effect sequencer and color of the current tick.
`timescale 1ns / 1ps
module rles_core (
  input  logic           clk,
  input  logic           rst,
  input  rles_pkg::cfg_t cfg,
  input  logic           restart,
  input  logic           step,
  input  logic           tick,
  output logic [7:0]     red,
  output logic [7:0]     green,
  output logic [7:0]     blue,
  output logic           done
);
  import rles_pkg::*;

  logic [3:0]  phase_index, phase_index_next;
  logic [15:0] ms_left, ms_left_next;
  logic [15:0] blinks_left, blinks_left_next;
  logic        finished, finished_next;
  logic [2:0]  col;
  logic        sequenced;
  logic [4:0]  idx_inc;
  logic        wrap;
  logic [3:0]  idx_new;

  assign done      = (cfg.effect_mode == MODE_LIMITED) && finished;
  assign col       = done ? HUE_BLACK : phase_color(cfg, phase_index);
  assign {red, green, blue} = palette(col);
  assign sequenced = (cfg.effect_mode >= MODE_BLINK) && (cfg.effect_mode <= MODE_PATROL);
  assign idx_inc   = {1'b0, phase_index} + 5'd1;
  assign wrap      = idx_inc >= phase_count(cfg.effect_mode);
  assign idx_new   = wrap ? 4'd0 : idx_inc[3:0];

  always_comb begin
    phase_index_next = phase_index;
    ms_left_next     = ms_left;
    blinks_left_next = blinks_left;
    finished_next    = finished;
    if (restart) begin
      phase_index_next = 4'd0;
      ms_left_next     = phase_len(cfg, 4'd0);
      blinks_left_next = cfg.blink_total;
      finished_next    = (cfg.effect_mode == MODE_LIMITED) && (cfg.blink_total == 16'd0);
    end else if (step && tick && sequenced && !done) begin
      if (ms_left > 16'd1) begin
        ms_left_next = ms_left - 16'd1;
      end else begin
        phase_index_next = idx_new;
        ms_left_next     = phase_len(cfg, idx_new);
        if (wrap && (cfg.effect_mode == MODE_LIMITED)) begin
          if (blinks_left != 16'd0) begin
            blinks_left_next = blinks_left - 16'd1;
          end
          if (blinks_left <= 16'd1) begin
            finished_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index <= 4'd0;
      ms_left     <= RST_MS_LEFT;
      blinks_left <= RST_BLINK_TOTAL;
      finished    <= 1'b0;
    end else begin
      phase_index <= phase_index_next;
      ms_left     <= ms_left_next;
      blinks_left <= blinks_left_next;
      finished    <= finished_next;
    end
  end

endmodule

// ----- rtl/rgb_led_effect_sequencer_top.sv -----
// A tick beat accepted into the input register yields its colour beat in the result register.
// Throughput: one tick beat per cycle while led_ready holds; the input register fills while a result waits.
// The phase counters advance when a tick moves from the input register to the result.
// Reset (rst, synchronous): patrol mode, white, 1 blink, 500 ms on, 0 ms off,
// phase 0 with 100 ms left; both pipeline registers empty.
`timescale 1ns / 1ps
module rgb_led_effect_sequencer_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rles_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        tick_valid,
  output logic                        tick_ready,
  input  logic                        tick,
  output logic                        led_valid,
  input  logic                        led_ready,
  output logic [7:0]                  red,
  output logic [7:0]                  green,
  output logic [7:0]                  blue,
  output logic                        limited_done
);
  import rles_pkg::*;

  cfg_t       cfg;
  logic       restart;
  logic       s1_valid;
  logic       s1_tick;
  logic       advance;
  logic [7:0] core_red, core_green, core_blue;
  logic       core_done;

  assign pready     = 1'b1;
  assign advance    = s1_valid && (!led_valid || led_ready);
  assign tick_ready = !s1_valid || advance;

  rles_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg),
    .restart (restart)
  );

  rles_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .restart (restart),
    .step    (advance),
    .tick    (s1_tick),
    .red     (core_red),
    .green   (core_green),
    .blue    (core_blue),
    .done    (core_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick_ready) begin
      s1_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && tick_ready) begin
      s1_tick <= tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_valid <= 1'b0;
    end else if (advance) begin
      led_valid <= 1'b1;
    end else if (led_ready) begin
      led_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      red          <= core_red;
      green        <= core_green;
      blue         <= core_blue;
      limited_done <= core_done;
    end
  end

endmodule

// ----- rtl/rles_checker.sv -----
// Port-level assertions of the LED effect sequencer and their bind.
`timescale 1ns / 1ps
`include "rgb_led_effect_sequencer_top_assert.svh"
module rles_checker (
  input logic       clk,
  input logic       rst,
  input logic       led_valid,
  input logic       led_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic       limited_done
);

  `RLES_ASSERT_NEXT(a_led_hold, clk, rst, led_valid && !led_ready, led_valid && $stable({red, green, blue, limited_done}), "led beat changed while stalled")
  `RLES_ASSERT_NOW(a_done_dark, clk, rst, led_valid && limited_done, red == 8'd0 && green == 8'd0 && blue == 8'd0, "finished limited blink not dark")
  `RLES_ASSERT_NOW(a_full_levels, clk, rst, led_valid, (red == 8'd0 || red == 8'd255) && (green == 8'd0 || green == 8'd255) && (blue == 8'd0 || blue == 8'd255), "colour level outside palette")
  `RLES_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !led_valid, "led beat present after reset")

endmodule

bind rgb_led_effect_sequencer_top rles_checker u_rles_checker (
  .clk          (clk),
  .rst          (rst),
  .led_valid    (led_valid),
  .led_ready    (led_ready),
  .red          (red),
  .green        (green),
  .blue         (blue),
  .limited_done (limited_done)
);
